/* src/crtu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crtu_pkg
// shared constants, codes and control types of the call/return trace unit
// ----------------------------------------------------------------------------
package crtu_pkg;

    localparam int FUNC_ENTRIES = 1024;
    localparam int TAIL_DEPTH   = 16;
    localparam int MAX_DEPTH    = 255;

    localparam int IDX_W     = $clog2(FUNC_ENTRIES);
    localparam int CNT_W     = $clog2(FUNC_ENTRIES + 1);
    localparam int TIDX_W    = $clog2(TAIL_DEPTH);
    localparam int TCNT_W    = $clog2(TAIL_DEPTH + 1);
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int IDX_OUT_W = 10;
    localparam int INDENT_W  = 8;
    localparam int INDENT_MAX = 255;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_CALL = 2'd1;
    localparam logic [1:0] CMD_RET  = 2'd2;

    localparam logic KIND_CALL = 1'b0;
    localparam logic KIND_RET  = 1'b1;

    typedef struct packed {
        logic take;
        logic scan_run;
        logic emit;
    } crtu_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_done;
        logic out_free;
        logic more;
    } crtu_sts_t;

    // start <= addr < start + size, sum taken on 33 bits
    function automatic logic in_range(input logic [31:0] addr,
                                      input logic [31:0] start,
                                      input logic [31:0] size);
        logic [32:0] hi;
        hi = {1'b0, start} + {1'b0, size};
        return (addr >= start) && ({1'b0, addr} < hi);
    endfunction

endpackage
`default_nettype wire

/* src/crtu_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crtu_ifs
// valid/ready channels for event items and trace record items
// ----------------------------------------------------------------------------
interface crtu_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] pc;
    logic [31:0] target;
    logic        is_tail;
    logic [31:0] entry_start;
    logic [31:0] entry_size;

    modport source (output valid, command, pc, target, is_tail, entry_start, entry_size,
                    input ready);
    modport sink (input valid, command, pc, target, is_tail, entry_start, entry_size,
                  output ready);
endinterface

interface crtu_rec_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] record_pc;
    logic [31:0] record_target;
    logic [7:0]  indent;
    logic        from_found;
    logic [9:0]  from_index;
    logic        to_found;
    logic [9:0]  to_index;
    logic        tail_dropped;
    logic        last;

    modport source (output valid, kind, record_pc, record_target, indent, from_found,
                    from_index, to_found, to_index, tail_dropped, last,
                    input ready);
    modport sink (input valid, kind, record_pc, record_target, indent, from_found,
                  from_index, to_found, to_index, tail_dropped, last,
                  output ready);
endinterface
`default_nettype wire

/* src/crtu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crtu_ctrl
// sequencer: takes items, runs table scans, hands records to the output
// ----------------------------------------------------------------------------
module crtu_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire crtu_pkg::crtu_sts_t sts,
    output crtu_pkg::crtu_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.take     = (state_reg == ST_IDLE) && in_valid;
    assign cmd.scan_run = (state_reg == ST_SCAN);
    assign cmd.emit     = (state_reg == ST_EMIT) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && sts.needs_scan)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                    state_next = sts.more ? ST_SCAN : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* src/crtu_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crtu_datapath
// function table, depth and tail stack, range scan and output register
// ----------------------------------------------------------------------------
module crtu_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic                cfg_wdata,
    input  wire logic [1:0]          command,
    input  wire logic [31:0]         pc,
    input  wire logic [31:0]         target,
    input  wire logic                is_tail,
    input  wire logic [31:0]         entry_start,
    input  wire logic [31:0]         entry_size,
    input  wire crtu_pkg::crtu_cmd_t cmd,
    output crtu_pkg::crtu_sts_t      sts,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     out_kind,
    output logic [31:0]              out_pc,
    output logic [31:0]              out_target,
    output logic [7:0]               out_indent,
    output logic                     out_from_found,
    output logic [9:0]               out_from_index,
    output logic                     out_to_found,
    output logic [9:0]               out_to_index,
    output logic                     out_tail_dropped,
    output logic                     out_last
);

    localparam int CNT_W   = crtu_pkg::CNT_W;
    localparam int IDX_W   = crtu_pkg::IDX_W;
    localparam int DEPTH_W = crtu_pkg::DEPTH_W;
    localparam int TCNT_W  = crtu_pkg::TCNT_W;
    localparam int TIDX_W  = crtu_pkg::TIDX_W;

    // function table
    logic [31:0] start_mem [crtu_pkg::FUNC_ENTRIES];
    logic [31:0] size_mem  [crtu_pkg::FUNC_ENTRIES];

    // tail-call stack
    logic [31:0]        tpc_stk [crtu_pkg::TAIL_DEPTH];
    logic [DEPTH_W-1:0] tlvl_stk [crtu_pkg::TAIL_DEPTH];

    logic               trace_en_reg, trace_en_next;
    logic [CNT_W-1:0]   entry_cnt_reg, entry_cnt_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [TCNT_W-1:0]  tcnt_reg, tcnt_next;
    logic [CNT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               out_vld_reg, out_vld_next;

    logic               cur_kind_reg;
    logic [31:0]        cur_pc_reg;
    logic [31:0]        cur_tgt_reg;
    logic [DEPTH_W-1:0] cur_depth_reg;
    logic               cur_drop_reg;
    logic               ff_reg, tf_reg;
    logic [IDX_W-1:0]   fi_reg, ti_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [31:0]        rd_start_reg, rd_size_reg;

    logic               is_load, is_call, is_ret;
    logic               load_ok;
    logic [DEPTH_W-1:0] call_depth;
    logic [DEPTH_W-1:0] depth_dec;
    logic               call_emits, tail_full, push_ok;
    logic               issuing, scan_start, pop;
    logic [TIDX_W-1:0]  top;
    logic               pc_hit, tgt_hit;

    assign is_load = cmd.take && (command == crtu_pkg::CMD_LOAD);
    assign is_call = cmd.take && (command == crtu_pkg::CMD_CALL) && trace_en_reg;
    assign is_ret  = cmd.take && (command == crtu_pkg::CMD_RET) && trace_en_reg;
    assign load_ok = is_load && (entry_cnt_reg < CNT_W'(crtu_pkg::FUNC_ENTRIES));

    assign call_depth = (depth_reg < DEPTH_W'(crtu_pkg::MAX_DEPTH)) ?
                        depth_reg + DEPTH_W'(1) : depth_reg;
    assign depth_dec  = (depth_reg != '0) ? depth_reg - DEPTH_W'(1) : depth_reg;
    assign call_emits = (call_depth > DEPTH_W'(1));
    assign tail_full  = (tcnt_reg == TCNT_W'(crtu_pkg::TAIL_DEPTH));
    assign push_ok    = is_call && call_emits && is_tail && !tail_full;

    assign top     = TIDX_W'(tcnt_reg - TCNT_W'(1));
    assign sts.more = (cur_kind_reg == crtu_pkg::KIND_RET) && (tcnt_reg != '0) &&
                      (tlvl_stk[top] == depth_reg);
    assign pop      = cmd.emit && sts.more;

    assign sts.needs_scan = ((command == crtu_pkg::CMD_CALL) && trace_en_reg && call_emits) ||
                            ((command == crtu_pkg::CMD_RET) && trace_en_reg);
    assign scan_start = (is_call && call_emits) || is_ret || pop;

    assign issuing       = cmd.scan_run && (scan_cnt_reg < entry_cnt_reg);
    assign sts.scan_done = cmd.scan_run && !issuing && !rd_vld_reg;
    assign sts.out_free  = !out_vld_reg || out_ready;

    assign pc_hit  = crtu_pkg::in_range(cur_pc_reg, rd_start_reg, rd_size_reg);
    assign tgt_hit = crtu_pkg::in_range(cur_tgt_reg, rd_start_reg, rd_size_reg);

    always_comb
    begin
        trace_en_next  = cfg_we ? cfg_wdata : trace_en_reg;
        entry_cnt_next = load_ok ? entry_cnt_reg + CNT_W'(1) : entry_cnt_reg;
        depth_next     = depth_reg;
        tcnt_next      = tcnt_reg;
        if (is_call)
            depth_next = call_depth;
        else if (is_ret || pop)
            depth_next = depth_dec;
        if (push_ok)
            tcnt_next = tcnt_reg + TCNT_W'(1);
        else if (pop)
            tcnt_next = tcnt_reg - TCNT_W'(1);
        scan_cnt_next = scan_start ? '0 : (issuing ? scan_cnt_reg + CNT_W'(1) : scan_cnt_reg);
        rd_vld_next   = issuing;
        out_vld_next  = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_en_reg  <= 1'b0;
            entry_cnt_reg <= '0;
            depth_reg     <= '0;
            tcnt_reg      <= '0;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            trace_en_reg  <= trace_en_next;
            entry_cnt_reg <= entry_cnt_next;
            depth_reg     <= depth_next;
            tcnt_reg      <= tcnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // table write on load, registered read during the scan
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            start_mem[entry_cnt_reg[IDX_W-1:0]] <= entry_start;
            size_mem[entry_cnt_reg[IDX_W-1:0]]  <= entry_size;
        end
        if (issuing)
        begin
            rd_start_reg <= start_mem[scan_cnt_reg[IDX_W-1:0]];
            rd_size_reg  <= size_mem[scan_cnt_reg[IDX_W-1:0]];
            rd_idx_reg   <= scan_cnt_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            tpc_stk[tcnt_reg[TIDX_W-1:0]]  <= pc;
            tlvl_stk[tcnt_reg[TIDX_W-1:0]] <= call_depth - DEPTH_W'(1);
        end
    end

    // current record and scan results
    always_ff @(posedge clk)
    begin
        if (is_call)
        begin
            cur_kind_reg  <= crtu_pkg::KIND_CALL;
            cur_pc_reg    <= pc;
            cur_tgt_reg   <= target;
            cur_depth_reg <= call_depth;
            cur_drop_reg  <= is_tail && tail_full;
        end
        else if (is_ret)
        begin
            cur_kind_reg  <= crtu_pkg::KIND_RET;
            cur_pc_reg    <= pc;
            cur_tgt_reg   <= '0;
            cur_depth_reg <= depth_reg;
            cur_drop_reg  <= 1'b0;
        end
        else if (pop)
        begin
            cur_pc_reg    <= tpc_stk[top];
            cur_depth_reg <= depth_reg;
        end
        if (scan_start)
        begin
            ff_reg <= 1'b0;
            tf_reg <= 1'b0;
            fi_reg <= '0;
            ti_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            if (!ff_reg && pc_hit)
            begin
                ff_reg <= 1'b1;
                fi_reg <= rd_idx_reg;
            end
            if (!tf_reg && tgt_hit)
            begin
                tf_reg <= 1'b1;
                ti_reg <= rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind         <= cur_kind_reg;
            out_pc           <= cur_pc_reg;
            out_target       <= cur_tgt_reg;
            out_indent       <= (32'(cur_depth_reg) > 32'(crtu_pkg::INDENT_MAX)) ?
                                crtu_pkg::INDENT_W'(crtu_pkg::INDENT_MAX) :
                                crtu_pkg::INDENT_W'(cur_depth_reg);
            out_from_found   <= ff_reg;
            out_from_index   <= crtu_pkg::IDX_OUT_W'(fi_reg);
            out_to_found     <= (cur_kind_reg == crtu_pkg::KIND_CALL) && tf_reg;
            out_to_index     <= (cur_kind_reg == crtu_pkg::KIND_CALL) ?
                                crtu_pkg::IDX_OUT_W'(ti_reg) : '0;
            out_tail_dropped <= cur_drop_reg;
            out_last         <= !sts.more;
        end
    end

    assign out_valid = out_vld_reg;

endmodule
`default_nettype wire

/* src/call_return_trace_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// call_return_trace_unit
// flow: a load item is taken without a scan; each record runs its own table scan,
//   one table entry read per cycle, then the read and compare drain, then the
//   hand-off to output
// one item in flight; a return unwinding k tail calls gives 1 + k records,
//   each with its own table scan
// reset: asynchronous, active low; table and tail stack empty, depth 0, tracing off
// ----------------------------------------------------------------------------
module call_return_trace_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    crtu_evt_if.sink  evt,
    crtu_rec_if.source rec
);

    // command and status between sequencer and datapath
    crtu_pkg::crtu_cmd_t cmd;
    crtu_pkg::crtu_sts_t sts;

    // sequencer: idle -> scan -> emit, looping back to scan while tail calls unwind
    crtu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (evt.valid),
        .in_ready (evt.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table memory, depth counter, tail stack, range scan and record register
    crtu_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .command          (evt.command),
        .pc               (evt.pc),
        .target           (evt.target),
        .is_tail          (evt.is_tail),
        .entry_start      (evt.entry_start),
        .entry_size       (evt.entry_size),
        .cmd              (cmd),
        .sts              (sts),
        .out_valid        (rec.valid),
        .out_ready        (rec.ready),
        .out_kind         (rec.kind),
        .out_pc           (rec.record_pc),
        .out_target       (rec.record_target),
        .out_indent       (rec.indent),
        .out_from_found   (rec.from_found),
        .out_from_index   (rec.from_index),
        .out_to_found     (rec.to_found),
        .out_to_index     (rec.to_index),
        .out_tail_dropped (rec.tail_dropped),
        .out_last         (rec.last)
    );

endmodule
`default_nettype wire

/* src/crtu_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crtu_checker
// port-level checks on the trace record channel
// ----------------------------------------------------------------------------
module crtu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rec_valid,
    input wire logic        rec_ready,
    input wire logic        rec_kind,
    input wire logic [31:0] rec_target,
    input wire logic        rec_to_found,
    input wire logic        rec_tail_dropped,
    input wire logic        rec_from_found,
    input wire logic [9:0]  rec_from_index,
    input wire logic        rec_last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_ready |=> rec_valid)
        else $error("record dropped while stalled");

    a_call_last: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_kind |-> rec_last)
        else $error("call record not last");

    a_ret_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_kind |-> rec_target == 32'd0 && !rec_to_found && !rec_tail_dropped)
        else $error("return record carries call fields");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && !rec_from_found |-> rec_from_index == 10'd0)
        else $error("index set on a miss");

endmodule

bind call_return_trace_unit crtu_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .rec_valid        (rec.valid),
    .rec_ready        (rec.ready),
    .rec_kind         (rec.kind),
    .rec_target       (rec.record_target),
    .rec_to_found     (rec.to_found),
    .rec_tail_dropped (rec.tail_dropped),
    .rec_from_found   (rec.from_found),
    .rec_from_index   (rec.from_index),
    .rec_last         (rec.last)
);
`default_nettype wire

/* tb/call_return_trace_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// call_return_trace_unit_tb
// self-checking bench: function table loads, calls, tail calls and returns
// are pushed through a bursty sender, each accepted item is fed to a local
// call tracer model, and every trace record is checked field by field
// ----------------------------------------------------------------------------
module call_return_trace_unit_tb;

    localparam logic [1:0] CMD_BAD = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] pc;
        logic [31:0] target;
        logic        is_tail;
        logic [31:0] entry_start;
        logic [31:0] entry_size;
    } event_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] record_pc;
        logic [31:0] record_target;
        logic [7:0]  indent;
        logic        from_found;
        logic [9:0]  from_index;
        logic        to_found;
        logic [9:0]  to_index;
        logic        tail_dropped;
        logic        last;
    } trace_record_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    crtu_evt_if evt ();
    crtu_rec_if rec ();

    call_return_trace_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .evt       (evt.sink),
        .rec       (rec.source)
    );

    // model state of the tracer
    logic        mdl_enable;
    logic [31:0] mdl_start [crtu_pkg::FUNC_ENTRIES];
    logic [31:0] mdl_size  [crtu_pkg::FUNC_ENTRIES];
    int          mdl_count;
    int          mdl_depth;
    logic [31:0] mdl_tail_pc  [crtu_pkg::TAIL_DEPTH];
    int          mdl_tail_lvl [crtu_pkg::TAIL_DEPTH];
    int          mdl_tail_cnt;

    event_item_t   pending_items [$];
    trace_record_t expected_records [$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  records_seen = 0;
    int  calls_seen = 0;
    int  unwinds_seen = 0;
    int  drops_seen = 0;
    bit  hold_req = 0;     // start of the long receiver hold-off
    bit  hold_rx = 0;      // long receiver hold-off in progress
    bit  hold_tx = 0;      // sender pause request
    int  tx_gap = 0;
    int  rx_phase = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        wait (hold_req);
        hold_rx = 1'b1;
        repeat (3000) @(posedge clk);
        hold_rx = 1'b0;
    end

    // first-match search over the loaded part of the function table
    function automatic void find_function(input logic [31:0] addr,
                                          output logic found, output logic [9:0] idx);
        logic [32:0] hi;
        found = 1'b0;
        idx = '0;
        for (int i = 0; i < mdl_count; i++)
        begin
            hi = {1'b0, mdl_start[i]} + {1'b0, mdl_size[i]};
            if (addr >= mdl_start[i] && {1'b0, addr} < hi)
            begin
                found = 1'b1;
                idx = i[9:0];
                return;
            end
        end
    endfunction

    function automatic trace_record_t make_record(input logic kind, input logic [31:0] pc,
                                                  input logic [31:0] tgt, input int depth,
                                                  input logic dropped);
        trace_record_t r;
        r = '0;
        r.kind = kind;
        r.record_pc = pc;
        r.indent = (depth > crtu_pkg::INDENT_MAX) ? 8'(crtu_pkg::INDENT_MAX) : 8'(depth);
        find_function(pc, r.from_found, r.from_index);
        if (kind == crtu_pkg::KIND_CALL)
        begin
            r.record_target = tgt;
            find_function(tgt, r.to_found, r.to_index);
        end
        r.tail_dropped = dropped;
        return r;
    endfunction

    // advance the model by one accepted item and queue what it should emit
    task automatic predict_trace(input event_item_t it);
        trace_record_t r;
        logic dropped;
        if (it.command == crtu_pkg::CMD_LOAD)
        begin
            if (mdl_count < crtu_pkg::FUNC_ENTRIES)
            begin
                mdl_start[mdl_count] = it.entry_start;
                mdl_size[mdl_count] = it.entry_size;
                mdl_count++;
            end
            return;
        end
        if (it.command == CMD_BAD || !mdl_enable)
            return;
        if (it.command == crtu_pkg::CMD_CALL)
        begin
            dropped = 1'b0;
            if (mdl_depth < crtu_pkg::MAX_DEPTH)
                mdl_depth++;
            if (mdl_depth <= 1)
                return;
            if (it.is_tail)
            begin
                if (mdl_tail_cnt < crtu_pkg::TAIL_DEPTH)
                begin
                    mdl_tail_pc[mdl_tail_cnt] = it.pc;
                    mdl_tail_lvl[mdl_tail_cnt] = mdl_depth - 1;
                    mdl_tail_cnt++;
                end
                else
                    dropped = 1'b1;
            end
            r = make_record(crtu_pkg::KIND_CALL, it.pc, it.target, mdl_depth, dropped);
            r.last = 1'b1;
            expected_records.push_back(r);
            return;
        end
        // return: own record, then unwind tail calls sitting at the new depth
        expected_records.push_back(make_record(crtu_pkg::KIND_RET, it.pc, '0, mdl_depth,
                                               1'b0));
        if (mdl_depth > 0)
            mdl_depth--;
        while (mdl_tail_cnt > 0 && mdl_tail_lvl[mdl_tail_cnt - 1] == mdl_depth)
        begin
            mdl_tail_cnt--;
            expected_records.push_back(make_record(crtu_pkg::KIND_RET,
                                                   mdl_tail_pc[mdl_tail_cnt],
                                                   '0, mdl_depth, 1'b0));
            if (mdl_depth > 0)
                mdl_depth--;
        end
        expected_records[expected_records.size() - 1].last = 1'b1;
    endtask

    // sender: bursts with random gaps, honors a pause request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt.valid <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (evt.valid && evt.ready)
            begin
                predict_trace({evt.command, evt.pc, evt.target, evt.is_tail,
                               evt.entry_start, evt.entry_size});
                items_sent++;
            end
            if (!evt.valid || evt.ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    evt.valid <= 1'b0;
                end
                else if (pending_items.size() > 0 && !hold_tx)
                begin
                    {evt.command, evt.pc, evt.target, evt.is_tail,
                     evt.entry_start, evt.entry_size} <= pending_items.pop_front();
                    evt.valid <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        tx_gap <= $urandom_range(1, 12);
                end
                else
                    evt.valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern that drifts between phases, plus long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec.ready <= 1'b0;
            rx_phase <= 0;
        end
        else
        begin
            if (rec.valid && rec.ready)
            begin
                records_seen++;
                if (expected_records.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected record pc=%h kind=%0d", rec.record_pc, rec.kind);
                end
                else
                begin
                    trace_record_t e;
                    trace_record_t a;
                    e = expected_records.pop_front();
                    a = {rec.kind, rec.record_pc, rec.record_target, rec.indent,
                         rec.from_found, rec.from_index, rec.to_found, rec.to_index,
                         rec.tail_dropped, rec.last};
                    if (a.kind == crtu_pkg::KIND_CALL)
                        calls_seen++;
                    if (a.tail_dropped)
                        drops_seen++;
                    if (a.kind == crtu_pkg::KIND_RET && !a.last)
                        unwinds_seen++;
                    if (a !== e)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("record mismatch: expected %p actual %p", e, a);
                    end
                end
            end
            rx_phase <= rx_phase + 1;
            if (hold_rx)
                rec.ready <= 1'b0;
            else if ((rx_phase / 64) % 3 == 0)
                rec.ready <= 1'b1;             // stretch with no stalls
            else
                rec.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || evt.valid || expected_records.size() > 0)
            @(posedge clk);
    endtask

    task automatic write_enable(input logic v);
        wait_drained();
        repeat (1100) @(posedge clk);   // a scan with no record may still be running
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        mdl_enable = v;
    endtask

    function automatic event_item_t mk(input logic [1:0] c, input logic [31:0] p,
                                       input logic [31:0] t, input logic tl,
                                       input logic [31:0] s, input logic [31:0] z);
        event_item_t it;
        it = {c, p, t, tl, s, z};
        return it;
    endfunction

    // pc near a loaded function most of the time
    function automatic logic [31:0] pick_addr();
        if ($urandom_range(0, 9) < 7)
            return 32'h1000 + $urandom_range(0, 8) * 32'h100 + $urandom_range(0, 255);
        return $urandom;
    endfunction

    task automatic queue_random_call_tree(input int n);
        int d;
        d = 0;
        for (int i = 0; i < n; i++)
        begin
            if (d < 6 && $urandom_range(0, 1))
            begin
                pending_items.push_back(mk(crtu_pkg::CMD_CALL, pick_addr(), pick_addr(),
                                           $urandom_range(0, 2) == 0, $urandom, $urandom));
                d++;
            end
            else
            begin
                pending_items.push_back(mk(crtu_pkg::CMD_RET, pick_addr(), $urandom,
                                           1'($urandom_range(0, 1)), $urandom, $urandom));
                if (d > 0)
                    d--;
            end
            if ($urandom_range(0, 19) == 0)
                pending_items.push_back(mk(2'($urandom_range(0, 3)), $urandom, $urandom,
                                           1'($urandom_range(0, 1)), $urandom, $urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        evt.valid = 1'b0;
        evt.command = crtu_pkg::CMD_LOAD;
        evt.pc = '0;
        evt.target = '0;
        evt.is_tail = 1'b0;
        evt.entry_start = '0;
        evt.entry_size = '0;
        rec.ready = 1'b0;
        mdl_enable = 1'b0;
        mdl_count = 0;
        mdl_depth = 0;
        mdl_tail_cnt = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tracing off: call and return ignored, loads still land
        pending_items.push_back(mk(crtu_pkg::CMD_CALL, 32'h1010, 32'h1110, 1'b0, '0, '0));
        pending_items.push_back(mk(crtu_pkg::CMD_RET, 32'h1010, '0, 1'b0, '0, '0));
        pending_items.push_back(mk(crtu_pkg::CMD_LOAD, '0, '0, 1'b0, 32'h1000, 32'h100));
        pending_items.push_back(mk(crtu_pkg::CMD_LOAD, '0, '0, 1'b0, 32'h1000, 32'h200));
        pending_items.push_back(mk(crtu_pkg::CMD_LOAD, '0, '0, 1'b0, 32'hFFFF_FF00,
                                   32'hFFFF_FFFF));
        pending_items.push_back(mk(crtu_pkg::CMD_LOAD, '0, '0, 1'b0, 32'h0, 32'h0));
        for (int i = 2; i < 9; i++)
            pending_items.push_back(mk(crtu_pkg::CMD_LOAD, '0, '0, 1'b0,
                                       32'h1000 + i * 32'h100, 32'h100));
        write_enable(1'b1);

        // first call silent, nested calls, tail chain unwinding, bad command
        pending_items.push_back(mk(crtu_pkg::CMD_CALL, 32'h1004, 32'h1104, 1'b0, '0, '0));
        pending_items.push_back(mk(crtu_pkg::CMD_CALL, 32'h1104, 32'h1204, 1'b0, '0, '0));
        pending_items.push_back(mk(crtu_pkg::CMD_CALL, 32'h1204, 32'hFFFF_FFFF, 1'b1,
                                   '0, '0));
        pending_items.push_back(mk(crtu_pkg::CMD_CALL, 32'hFFFF_FFFF, 32'h0, 1'b1, '0, '0));
        pending_items.push_back(mk(CMD_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_items.push_back(mk(crtu_pkg::CMD_RET, 32'h0, '0, 1'b0, '0, '0));
        pending_items.push_back(mk(crtu_pkg::CMD_RET, 32'h1100, '0, 1'b0, '0, '0));
        // returns at depth zero
        for (int i = 0; i < 3; i++)
            pending_items.push_back(mk(crtu_pkg::CMD_RET, 32'h1300, '0, 1'b0, '0, '0));
        wait_drained();

        // overfill the tail stack, then a single return
        pending_items.push_back(mk(crtu_pkg::CMD_CALL, 32'h1010, 32'h1110, 1'b0, '0, '0));
        for (int i = 0; i < crtu_pkg::TAIL_DEPTH + 2; i++)
            pending_items.push_back(mk(crtu_pkg::CMD_CALL, 32'h1000 + i * 16, pick_addr(),
                                       1'b1, '0, '0));
        pending_items.push_back(mk(crtu_pkg::CMD_RET, 32'h1800, '0, 1'b0, '0, '0));
        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        queue_random_call_tree(20);
        wait_drained();

        // random part, then a sender pause until every record is back
        queue_random_call_tree(40);
        repeat (150) @(posedge clk);
        hold_tx = 1'b1;
        while (evt.valid || expected_records.size() > 0)
            @(posedge clk);
        hold_tx = 1'b0;
        wait_drained();

        // tracing off again for a short stretch
        write_enable(1'b0);
        queue_random_call_tree(10);
        write_enable(1'b1);

        // drive depth to saturation, then a few returns from the top
        for (int i = 0; i < crtu_pkg::MAX_DEPTH + 3; i++)
            pending_items.push_back(mk(crtu_pkg::CMD_CALL, 32'h1020, 32'h1120, 1'b0,
                                       '0, '0));
        for (int i = 0; i < 4; i++)
            pending_items.push_back(mk(crtu_pkg::CMD_RET, 32'h1120, '0, 1'b0, '0, '0));
        wait_drained();
        repeat (1100) @(posedge clk);

        $display("sent %0d items, checked %0d records (%0d calls, %0d tail unwinds, %0d drops)",
                 items_sent, records_seen, calls_seen, unwinds_seen, drops_seen);
        $display("covered tracing on and off, tail stack overflow, long output stalls, depth limits");
        if (mismatches == 0 && expected_records.size() == 0)
            $display("call_return_trace_unit_tb OK");
        else
        begin
            $display("%0d mismatches, %0d records missing", mismatches, expected_records.size());
            $display("call_return_trace_unit_tb NOT OK");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout");
        $display("call_return_trace_unit_tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
src/crtu_pkg.sv
src/crtu_ifs.sv
src/crtu_ctrl.sv
src/crtu_datapath.sv
src/call_return_trace_unit.sv
src/crtu_checker.sv
tb/call_return_trace_unit_tb.sv
